>>> design/spfc_pkg.sv
package spfc_pkg;

  localparam int WINDOW_LEN_DEF = 10;

  localparam logic signed [15:0] PI_Q13     = 16'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
  localparam logic signed [19:0] PI_Q16     = 20'sd205887;

  localparam logic [2:0] CFG_DIST_P   = 3'd0;
  localparam logic [2:0] CFG_DIST_I   = 3'd1;
  localparam logic [2:0] CFG_HEADING  = 3'd2;
  localparam logic [2:0] CFG_SPEED_P  = 3'd3;
  localparam logic [2:0] CFG_SPEED_I  = 3'd4;
  localparam logic [2:0] CFG_STANDOFF = 3'd5;
  localparam logic [2:0] CFG_THR_MAX  = 3'd6;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] thrust;
    logic signed [31:0] steering;
  } out_item_t;

  function automatic logic [19:0] atan_q16(input logic [3:0] i);
    logic [19:0] r;
    case (i)
      4'd0: r = 20'd51472;
      4'd1: r = 20'd30385;
      4'd2: r = 20'd16055;
      4'd3: r = 20'd8150;
      4'd4: r = 20'd4091;
      4'd5: r = 20'd2047;
      4'd6: r = 20'd1024;
      4'd7: r = 20'd512;
      4'd8: r = 20'd256;
      4'd9: r = 20'd128;
      4'd10: r = 20'd64;
      4'd11: r = 20'd32;
      4'd12: r = 20'd16;
      4'd13: r = 20'd8;
      4'd14: r = 20'd4;
      default: r = 20'd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

>>> design/spfc_ram.sv
module spfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/standoff_pi_follow_controller.sv
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_stall   | spfc_pkg::in_item_t
// out      | output    | out_valid/out_stall | spfc_pkg::out_item_t
// cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// One transaction runs 33 root steps, the scaling doublings d (0 to 32, most for short
// vectors), 16 CORDIC steps and the multiply and divide steps. A new input is taken only
// while the block is idle. The window memory (one RAM, both errors per word) is read at
// load and written at the end. Reset clears counters and sums; never-written window
// words are not used. A stalled result holds in the output register; the next input
// waits for it.
module standoff_pi_follow_controller #(
  parameter int WINDOW_LEN = spfc_pkg::WINDOW_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spfc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spfc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW = $clog2(WINDOW_LEN + 1);
  localparam logic signed [63:0] DIV_BIAS = 64'sd5 <<< 43;
  localparam logic [47:0] Q_BIAS = 48'd1 << 43;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_SCALE, S_CORDIC, S_M1, S_M2, S_M3, S_M4, S_M5, S_DONE,
    S_DA, S_DB, S_DC, S_DD, S_DE
  } state_t;

  state_t state;
  logic signed [15:0] kp, ki, kh, kpv, kiv;
  logic [30:0] standoff;
  logic signed [31:0] thmax;

  logic signed [32:0] dx, dy;
  logic signed [15:0] hd;
  logic signed [31:0] spd;
  logic [65:0] sq;
  logic [33:0] rem;
  logic [32:0] root;
  logic [5:0] cnt;
  logic signed [39:0] cx, cy;
  logic signed [21:0] z;
  logic signed [21:0] base;
  logic zero_vec;
  logic signed [31:0] e, ev;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [39:0] dsum, ssum;
  logic [AW-1:0] head;
  logic [FW-1:0] fill;
  logic signed [17:0] eth;
  logic [47:0] du, dq;
  logic [9:0] dr;
  logic signed [63:0] quo;
  logic pass2;

  logic ram_we;
  logic [63:0] ram_rd;
  logic [AW-1:0] head_plus;

  spfc_ram #(.WIDTH(64), .DEPTH(WINDOW_LEN)) u_win (
    .clk(clk), .we(ram_we), .waddr(head), .wdata({e, ev}), .raddr(head),
    .rdata(ram_rd)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign ram_we    = (state == S_DONE);
  assign head_plus = (head == AW'(WINDOW_LEN - 1)) ? '0 : head + 1'b1;

  // root step
  logic [35:0] r_rem, r_trial;
  logic [1:0] r_pair;
  always_comb begin
    r_pair  = sq[65:64];
    r_rem   = {rem, r_pair};
    r_trial = {1'b0, root, 2'b01};
  end

  logic signed [39:0] xs, ys;
  logic [3:0] ci;
  assign ci = cnt[3:0];
  assign xs = cx >>> ci;
  assign ys = cy >>> ci;

  logic signed [39:0] ax, ay;
  assign ax = cx[39] ? -cx : cx;
  assign ay = cy[39] ? -cy : cy;

  logic signed [63:0] dist_e;
  assign dist_e = $signed({31'd0, root}) - $signed({33'd0, standoff});

  logic signed [21:0] angq;
  logic signed [18:0] a13;
  logic signed [18:0] th_d;
  assign angq = base + z + 22'sd4;
  assign a13  = angq[21:3];
  always_comb begin
    th_d = a13;
    if (zero_vec) th_d = '0;
    else if (a13 < -19'sd25736) th_d = a13 + 19'sd51472;
    else if (a13 > 19'sd25736) th_d = a13 - 19'sd51472;
  end

  logic signed [18:0] eraw;
  assign eraw = 19'(hd) - th_d;

  // floor(acc / 2560): floor(acc / 512) biased positive, then divided by 5 through
  // a shift-add series for 1/5 that never overshoots and a small remainder fix-up
  logic signed [63:0] acc_sh;
  logic [47:0] dvd_in, q_a, q_b, dq_fin;
  logic [17:0] dfix;
  assign acc_sh = acc >>> 9;
  assign dvd_in = 48'(acc_sh + DIV_BIAS);
  assign q_a    = dq + (dq >> 4);
  assign q_b    = dq + (dq >> 16);
  assign dfix   = 18'(dr) * 18'd205;
  assign dq_fin = dq + 48'(dfix[17:10]) - Q_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      kp <= 16'sd26; ki <= 16'sd26; kh <= 16'sd26;
      kpv <= 16'sd256; kiv <= 16'sd256;
      standoff <= 31'd78643; thmax <= 32'sd223477;
      dsum <= '0; ssum <= '0; head <= '0; fill <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          spfc_pkg::CFG_DIST_P:   kp <= cfg_data[15:0];
          spfc_pkg::CFG_DIST_I:   ki <= cfg_data[15:0];
          spfc_pkg::CFG_HEADING:  kh <= cfg_data[15:0];
          spfc_pkg::CFG_SPEED_P:  kpv <= cfg_data[15:0];
          spfc_pkg::CFG_SPEED_I:  kiv <= cfg_data[15:0];
          spfc_pkg::CFG_STANDOFF: standoff <= cfg_data[30:0];
          spfc_pkg::CFG_THR_MAX:  thmax <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            logic signed [32:0] ddx, ddy;
            logic [32:0] adx, ady;
            ddx = 33'(in_data.pos_x) - 33'(in_data.target_x);
            ddy = 33'(in_data.pos_y) - 33'(in_data.target_y);
            adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
            ady = ddy[32] ? 33'(-ddy) : 33'(ddy);
            dx <= ddx; dy <= ddy;
            hd <= in_data.heading; spd <= in_data.speed;
            sq <= 66'(adx * adx) + 66'(ady * ady);
            rem <= '0; root <= '0; cnt <= '0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (r_rem >= r_trial) begin
            rem <= 34'(r_rem - r_trial);
            root <= {root[31:0], 1'b1};
          end else begin
            rem <= r_rem[33:0];
            root <= {root[31:0], 1'b0};
          end
          sq <= {sq[63:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == 6'd32) begin
            zero_vec <= (dx == 0) && (dy == 0);
            if (dx < 0) begin
              base <= (dy >= 0) ? 22'(spfc_pkg::PI_Q16) : -22'(spfc_pkg::PI_Q16);
              cx <= -40'(dx); cy <= -40'(dy);
            end else begin
              base <= '0;
              cx <= 40'(dx); cy <= 40'(dy);
            end
            z <= '0;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          e <= spfc_pkg::sat32(dist_e);
          if (zero_vec || ax >= 40'sh100000000 || ay >= 40'sh100000000) begin
            cnt <= '0;
            state <= S_CORDIC;
          end else begin
            cx <= cx <<< 1; cy <= cy <<< 1;
          end
        end
        S_CORDIC: begin
          if (cy > 0) begin
            cx <= cx + ys; cy <= cy - xs; z <= z + 22'(spfc_pkg::atan_q16(ci));
          end else begin
            cx <= cx - ys; cy <= cy + xs; z <= z - 22'(spfc_pkg::atan_q16(ci));
          end
          cnt <= cnt + 1'b1;
          if (ci == 4'd15) state <= S_M1;
        end
        S_M1: begin
          if (eraw < -19'sd25736) eth <= 18'(eraw + 19'sd51472);
          else if (eraw > 19'sd25736) eth <= 18'(eraw - 19'sd51472);
          else eth <= 18'(eraw);
          prod <= 64'(kp) * 64'(e);
          state <= S_M2;
        end
        S_M2: begin
          acc <= prod * 64'sd10 + 64'(ki) * 64'(dsum);
          out_data.steering <= spfc_pkg::sat32((64'(kh) * 64'(eth)) >>> 5);
          pass2 <= 1'b0;
          state <= S_DA;
        end
        S_DA: begin
          du <= dvd_in;
          dq <= (dvd_in >> 3) + (dvd_in >> 4);
          state <= S_DB;
        end
        S_DB: begin
          dq <= q_a + (q_a >> 8);
          state <= S_DC;
        end
        S_DC: begin
          dq <= q_b + (q_b >> 32);
          state <= S_DD;
        end
        S_DD: begin
          dr <= 10'(du - ((dq << 2) + dq));
          state <= S_DE;
        end
        S_DE: begin
          quo <= 64'($signed(dq_fin));
          state <= pass2 ? S_M5 : S_M3;
        end
        S_M3: begin
          ev <= spfc_pkg::sat32(quo - 64'(spd));
          state <= S_M4;
        end
        S_M4: begin
          acc <= 64'(kpv) * 64'(ev) * 64'sd10 + 64'(kiv) * 64'(ssum);
          pass2 <= 1'b1;
          state <= S_DA;
        end
        S_M5: begin
          out_data.thrust <= spfc_pkg::sat32((quo > 64'(thmax)) ? 64'(thmax) : quo);
          state <= S_DONE;
        end
        S_DONE: begin
          if (fill == FW'(WINDOW_LEN)) begin
            dsum <= dsum + 40'(e) - 40'($signed(ram_rd[63:32]));
            ssum <= ssum + 40'(ev) - 40'($signed(ram_rd[31:0]));
          end else begin
            dsum <= dsum + 40'(e);
            ssum <= ssum + 40'(ev);
            fill <= fill + 1'b1;
          end
          head <= head_plus;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
